// ===== hw/rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the point mover: word formats, sequencer
// states, configuration register indexes and the root/divide unit interface.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // field widths
    localparam int COORD_W = 24;            // signed coordinate
    localparam int STEP_W  = 23;            // unsigned step length
    localparam int MAG_W   = COORD_W + 1;   // magnitude of a coordinate difference
    localparam int SQ_W    = 2 * MAG_W;     // product of two magnitudes
    localparam int REM_W   = MAG_W + 3;     // partial remainder of the shared unit
    localparam int CNT_W   = 5;

    // iteration counts of the shared unit
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(MAG_W);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(STEP_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 23'd20480;

    // request types
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      moving;
        logic                      arrived;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SQX,
        ST_SQY,
        ST_SQS,
        ST_CMP,
        ST_ROOT,
        ST_MULX,
        ST_SDIVX,
        ST_WDIVX,
        ST_MULY,
        ST_SDIVY,
        ST_WDIVY,
        ST_OUT
    } t_state;

    typedef enum logic {
        UOP_SQRT,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] result;
    } t_unit_rsp;

endpackage

// ===== hw/rtl/pmt_mul.sv =====
// ----------------------------------------------------------------------------
// pmt_mul
// Shared unsigned multiplier with a registered product, used for the
// squares of the deltas and step length and for the step-scaled deltas.
// ----------------------------------------------------------------------------
module pmt_mul (
    input  logic                      i_clk,
    input  logic [pmt_pkg::MAG_W-1:0] i_a,
    input  logic [pmt_pkg::MAG_W-1:0] i_b,
    output logic [pmt_pkg::SQ_W-1:0]  o_prod
);
    import pmt_pkg::*;

    logic [SQ_W-1:0] r_prod;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= SQ_W'(i_a) * SQ_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/pmt_sqdiv.sv =====
// ----------------------------------------------------------------------------
// pmt_sqdiv
// Shared restoring unit: integer square root of a wide square (two operand
// bits per cycle) or division of a step-scaled delta by the distance (one
// operand bit per cycle). One compare-subtract serves both.
// ----------------------------------------------------------------------------
module pmt_sqdiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pmt_pkg::t_unit_req        i_req,
    input  logic [pmt_pkg::SQ_W-1:0]  i_opnd,
    input  logic [pmt_pkg::MAG_W-1:0] i_dvs,
    output pmt_pkg::t_unit_rsp        o_rsp
);
    import pmt_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_unit_op          r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_root;
    logic [MAG_W-1:0]  r_dvs;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  diff;

    // one compare-subtract step
    always_comb begin
        if (r_op == UOP_SQRT) begin
            rem_sh = {r_rem[REM_W-3:0], r_acc[SQ_W-1 -: 2]};
            trial  = {1'b0, r_root, 2'b01};
        end else begin
            rem_sh = {r_rem[REM_W-2:0], r_acc[SQ_W-1]};
            trial  = {3'b000, r_dvs};
        end
        fits = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == UOP_SQRT) ? ROOT_STEPS : DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_dvs  <= i_dvs;
            r_root <= '0;
            if (i_req.op == UOP_SQRT) begin
                r_acc <= i_opnd;
                r_rem <= '0;
            end else begin
                // quotient fits in STEP_W bits, so the upper part is below the divisor
                r_acc <= {i_opnd[STEP_W-1:0], {(SQ_W-STEP_W){1'b0}}};
                r_rem <= REM_W'(i_opnd[SQ_W-3:STEP_W]);
            end
        end else if (r_busy) begin
            r_root <= {r_root[MAG_W-2:0], fits};
            r_rem  <= fits ? diff : rem_sh;
            if (r_op == UOP_SQRT) begin
                r_acc <= {r_acc[SQ_W-3:0], 2'b00};
            end else begin
                r_acc <= {r_acc[SQ_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_root;

endmodule

// ===== hw/rtl/point_move_toward_target.sv =====
// ----------------------------------------------------------------------------
// point_move_toward_target
// Steps a 2D point toward a configured target by a configured step length.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word at a time. A restart word loads
// the start position and sets the point moving; a tick word advances it.
// Every input word yields exactly one output word with the position after
// it, the moving flag and an arrived flag that is set only on the tick
// that snapped the point to the target.
// Latency: a restart, or a tick while stopped, shows its result the cycle
// after acceptance. A tick that reaches the target goes through the delta,
// the squaring states and the compare; a tick that advances goes on through
// the square root and the two divisions in the shared restoring unit, each
// with a done cycle, and the multiplier states between.
// Throughput: one word at a time; o_in_stall stays high from acceptance
// until the result word has been taken.
// Reset clears the position and motion and loads target 0,0 and step 5.0.
// While the receiver stalls, the result word holds and no input is taken.
// Configuration writes belong between words, while no word is in flight,
// and are used from the next tick on.
// ----------------------------------------------------------------------------
module point_move_toward_target (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pmt_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pmt_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [pmt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pmt_pkg::COORD_W-1:0]   i_cfg_data
);
    import pmt_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [COORD_W-1:0] r_tgt_x;
    logic signed [COORD_W-1:0] r_tgt_y;
    logic [STEP_W-1:0]         r_step;

    logic signed [COORD_W-1:0] r_cur_x;
    logic signed [COORD_W-1:0] r_cur_y;
    logic                      r_motion;
    logic                      r_arrived;

    logic [MAG_W-1:0] r_adx;
    logic [MAG_W-1:0] r_ady;
    logic             r_neg_x;
    logic             r_neg_y;
    logic [SQ_W-1:0]  r_d2;
    logic [MAG_W-1:0] r_dist;

    logic             in_acc;
    logic             out_acc;
    logic [MAG_W-1:0] dx;
    logic [MAG_W-1:0] dy;
    logic [MAG_W-1:0] mul_a;
    logic [MAG_W-1:0] mul_b;
    logic [SQ_W-1:0]  prod;
    logic             near;
    logic [COORD_W-1:0] q_ext;
    t_unit_req        unit_req;
    t_unit_rsp        unit_rsp;
    logic [SQ_W-1:0]  unit_opnd;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // signed deltas to the target, one bit wider than a coordinate
    assign dx = {r_tgt_x[COORD_W-1], r_tgt_x} - {r_cur_x[COORD_W-1], r_cur_x};
    assign dy = {r_tgt_y[COORD_W-1], r_tgt_y} - {r_cur_y[COORD_W-1], r_cur_y};

    // exact arrival test against the squared step
    assign near  = (r_d2 <= prod);
    assign q_ext = COORD_W'(unit_rsp.result);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x <= '0;
            r_tgt_y <= '0;
            r_step  <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_X: r_tgt_x <= i_cfg_data;
                CFG_TARGET_Y: r_tgt_y <= i_cfg_data;
                CFG_STEP_LEN: r_step  <= i_cfg_data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.req_type == REQ_RESTART || !r_motion) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DELTA;
                    end
                end
            end
            ST_DELTA: n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_SQS;
            ST_SQS:   n_state = ST_CMP;
            ST_CMP:   n_state = near ? ST_OUT : ST_ROOT;
            ST_ROOT:  n_state = unit_rsp.done ? ST_MULX : ST_ROOT;
            ST_MULX:  n_state = ST_SDIVX;
            ST_SDIVX: n_state = ST_WDIVX;
            ST_WDIVX: n_state = unit_rsp.done ? ST_MULY : ST_WDIVX;
            ST_MULY:  n_state = ST_SDIVY;
            ST_SDIVY: n_state = ST_WDIVY;
            ST_WDIVY: n_state = unit_rsp.done ? ST_OUT : ST_WDIVY;
            ST_OUT:   n_state = out_acc ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshakes, multiplier operands, unit requests
    always_comb begin
        o_in_stall     = (r_state != ST_IDLE);
        o_out_valid    = (r_state == ST_OUT);
        mul_a          = r_adx;
        mul_b          = r_adx;
        unit_req.start = 1'b0;
        unit_req.op    = UOP_SQRT;
        unit_opnd      = r_d2;
        unique case (r_state)
            ST_SQY: begin
                mul_a = r_ady;
                mul_b = r_ady;
            end
            ST_SQS: begin
                mul_a = MAG_W'(r_step);
                mul_b = MAG_W'(r_step);
            end
            ST_CMP: begin
                unit_req.start = !near;
            end
            ST_MULX: begin
                mul_a = MAG_W'(r_step);
                mul_b = r_adx;
            end
            ST_MULY: begin
                mul_a = MAG_W'(r_step);
                mul_b = r_ady;
            end
            ST_SDIVX, ST_SDIVY: begin
                unit_req.start = 1'b1;
                unit_req.op    = UOP_DIV;
                unit_opnd      = prod;
            end
            default: ;
        endcase
    end

    // point state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_motion  <= 1'b0;
            r_arrived <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && in_acc) begin
                r_arrived <= 1'b0;
                if (i_in_word.req_type == REQ_RESTART) begin
                    r_cur_x  <= i_in_word.start_x;
                    r_cur_y  <= i_in_word.start_y;
                    r_motion <= 1'b1;
                end
            end
            if (r_state == ST_CMP && near) begin
                r_cur_x   <= r_tgt_x;
                r_cur_y   <= r_tgt_y;
                r_motion  <= 1'b0;
                r_arrived <= 1'b1;
            end
            // move never overshoots, so the 24-bit sum cannot wrap
            if (r_state == ST_WDIVX && unit_rsp.done) begin
                r_cur_x <= r_neg_x ? r_cur_x - q_ext : r_cur_x + q_ext;
            end
            if (r_state == ST_WDIVY && unit_rsp.done) begin
                r_cur_y <= r_neg_y ? r_cur_y - q_ext : r_cur_y + q_ext;
            end
        end
    end

    // working registers of one tick
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DELTA) begin
            r_neg_x <= dx[MAG_W-1];
            r_neg_y <= dy[MAG_W-1];
            r_adx   <= dx[MAG_W-1] ? -dx : dx;
            r_ady   <= dy[MAG_W-1] ? -dy : dy;
        end
        if (r_state == ST_SQY) begin
            r_d2 <= prod;
        end
        if (r_state == ST_SQS) begin
            r_d2 <= r_d2 + prod;
        end
        if (r_state == ST_ROOT && unit_rsp.done) begin
            r_dist <= unit_rsp.result;
        end
    end

    pmt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pmt_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_opnd  (unit_opnd),
        .i_dvs   (r_dist),
        .o_rsp   (unit_rsp)
    );

    // result word, held while in the output state
    assign o_out_word.pos_x   = r_cur_x;
    assign o_out_word.pos_y   = r_cur_y;
    assign o_out_word.moving  = r_motion;
    assign o_out_word.arrived = r_arrived;

endmodule

// ===== hw/rtl/pmt_checker.sv =====
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks on the point mover, bound to the top level.
// ----------------------------------------------------------------------------
module pmt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  pmt_pkg::t_in_word             i_in_word,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  pmt_pkg::t_out_word            o_out_word
);
    import pmt_pkg::*;

    // no new word is taken while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // a taken result is not shown twice
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

    // arrival and motion are exclusive
    a_arrive_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.arrived && o_out_word.moving))
        else $error("arrived while moving");

    // a restart shows its start position next cycle
    a_restart_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.req_type == REQ_RESTART) |=>
        (o_out_valid && o_out_word.moving && !o_out_word.arrived &&
         o_out_word.pos_x == $past(i_in_word.start_x) &&
         o_out_word.pos_y == $past(i_in_word.start_y)))
        else $error("restart result wrong");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind point_move_toward_target pmt_checker u_pmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
